// ===== rtl/utv_pkg.sv =====
// Shared types and constants for the UTF-8 text validator.
// Used by every module of the block; depends on nothing else.

package utv_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_DEPTH   = 2;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

  localparam logic [15:0] MAX_BYTES_RST = 16'd8000;
  localparam logic [15:0] MAX_CP_RST    = 16'd2000;

  // Register index as decoded from paddr bit 2.
  localparam logic REG_MAX_BYTES = 1'b0;
  localparam logic REG_MAX_CP    = 1'b1;

  localparam logic [20:0] CP_MIN_2B    = 21'h00080;
  localparam logic [20:0] CP_MIN_3B    = 21'h00800;
  localparam logic [20:0] CP_MIN_4B    = 21'h10000;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] SURR_LO      = 21'h0D800;
  localparam logic [20:0] SURR_HI      = 21'h0DFFF;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_class_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_LONG  = 3'd1,
    ERR_BAD_LEAD  = 3'd2,
    ERR_BAD_CONT  = 3'd3,
    ERR_RANGE     = 3'd4,
    ERR_TRUNC     = 3'd5,
    ERR_TOO_MANY  = 3'd6
  } err_kind_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
    logic        over;
    logic        last;
  } qentry_t;

  typedef struct packed {
    logic      text_ok;
    err_kind_t error_kind;
    logic [15:0] char_count;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/utv_front.sv =====
// Front end: accepts message bytes, classifies them and checks the byte limit.
// Depends on utv_pkg; feeds utv_queue.

module utv_front
  import utv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  input  logic [15:0] max_bytes,
  input  qstat_t      q_stat,
  output logic        q_wr,
  output qentry_t     q_wdata
);

  logic [15:0] byte_total_r;
  logic [15:0] byte_total_nxt;
  byte_class_t cls;
  logic        accept;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;
  assign q_wr   = accept;

  always_comb begin
    case (in_data_byte) inside
      8'h09, 8'h0A:   cls = CLS_ASCII;
      [8'h00:8'h1F]:  cls = CLS_BAD;
      [8'h20:8'h7F]:  cls = CLS_ASCII;
      [8'h80:8'hBF]:  cls = CLS_CONT;
      [8'hC2:8'hDF]:  cls = CLS_LEAD2;
      [8'hE0:8'hEF]:  cls = CLS_LEAD3;
      [8'hF0:8'hF4]:  cls = CLS_LEAD4;
      default:        cls = CLS_BAD;
    endcase
  end

  always_comb begin
    q_wdata.data = in_data_byte;
    q_wdata.cls  = cls;
    q_wdata.over = (byte_total_r >= max_bytes);
    q_wdata.last = in_final_byte;
  end

  // The count restarts after the final byte of each message.
  always_comb begin
    byte_total_nxt = byte_total_r;
    if (accept) begin
      if (in_final_byte) begin
        byte_total_nxt = '0;
      end else if (byte_total_r != 16'hFFFF) begin
        byte_total_nxt = byte_total_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_total_r <= '0;
    end else begin
      byte_total_r <= byte_total_nxt;
    end
  end

endmodule

// ===== rtl/utv_queue.sv =====
// Short queue of classified bytes between the front end and the decoder.
// Depends on utv_pkg.

module utv_queue
  import utv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  qentry_t wdata,
  input  logic    rd,
  output qentry_t rdata,
  output qstat_t  stat
);

  qentry_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_wr, do_rd;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign rdata      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/utv_back.sv =====
// Back end: runs the UTF-8 decode state over queued bytes and builds results.
// Depends on utv_pkg; reads from utv_queue and holds a small result buffer.

module utv_back
  import utv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  qstat_t      q_stat,
  input  qentry_t     q_rdata,
  output logic        q_rd,
  input  logic [15:0] max_code_points,
  output logic        empty,
  input  logic        pop,
  output logic        out_text_ok,
  output logic [2:0]  out_error_kind,
  output logic [15:0] out_char_count
);

  logic [15:0] char_total_r, char_total_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  min_cls_r, min_cls_nxt;
  err_kind_t   err_r, err_nxt;

  result_t           obuf [OUT_DEPTH];
  logic [OPTR_W-1:0] ob_wr_r, ob_wr_nxt;
  logic [OPTR_W-1:0] ob_rd_r, ob_rd_nxt;
  logic [OCNT_W-1:0] ob_cnt_r, ob_cnt_nxt;

  logic        step;
  logic        ob_push, ob_pop;
  logic [20:0] code_min;
  logic [20:0] code_asm;
  logic [15:0] char_inc;
  result_t     res;

  assign step    = !q_stat.empty && (ob_cnt_r != OCNT_W'(OUT_DEPTH));
  assign q_rd    = step;
  assign ob_push = step && q_rdata.last;
  assign ob_pop  = pop && !empty;
  assign empty   = (ob_cnt_r == '0);

  assign out_text_ok    = obuf[ob_rd_r].text_ok;
  assign out_error_kind = obuf[ob_rd_r].error_kind;
  assign out_char_count = obuf[ob_rd_r].char_count;

  assign char_inc = (char_total_r != 16'hFFFF) ? char_total_r + 16'd1 : char_total_r;
  assign code_asm = {partial_r[14:0], q_rdata.data[5:0]};

  always_comb begin
    case (min_cls_r)
      2'd1:    code_min = CP_MIN_2B;
      2'd2:    code_min = CP_MIN_3B;
      default: code_min = CP_MIN_4B;
    endcase
  end

  // Decode one byte. A byte over the length limit overrides any earlier error,
  // and decoding stops once any error has been recorded.
  always_comb begin
    char_total_nxt = char_total_r;
    pending_nxt    = pending_r;
    partial_nxt    = partial_r;
    min_cls_nxt    = min_cls_r;
    err_nxt        = err_r;
    if (q_rdata.over) begin
      err_nxt = ERR_TOO_LONG;
    end else if (err_r == ERR_NONE) begin
      if (pending_r == 2'd0) begin
        case (q_rdata.cls)
          CLS_ASCII: begin
            pending_nxt    = 2'd0;
            partial_nxt    = '0;
            min_cls_nxt    = 2'd0;
            char_total_nxt = char_inc;
          end
          CLS_LEAD2: begin
            pending_nxt    = 2'd1;
            partial_nxt    = {16'd0, q_rdata.data[4:0]};
            min_cls_nxt    = 2'd1;
            char_total_nxt = char_inc;
          end
          CLS_LEAD3: begin
            pending_nxt    = 2'd2;
            partial_nxt    = {17'd0, q_rdata.data[3:0]};
            min_cls_nxt    = 2'd2;
            char_total_nxt = char_inc;
          end
          CLS_LEAD4: begin
            pending_nxt    = 2'd3;
            partial_nxt    = {18'd0, q_rdata.data[2:0]};
            min_cls_nxt    = 2'd3;
            char_total_nxt = char_inc;
          end
          default: begin
            err_nxt = ERR_BAD_LEAD;
          end
        endcase
      end else if (q_rdata.cls != CLS_CONT) begin
        err_nxt = ERR_BAD_CONT;
      end else begin
        partial_nxt = code_asm;
        pending_nxt = pending_r - 2'd1;
        if (pending_r == 2'd1) begin
          if (code_asm < code_min || code_asm > CP_MAX ||
              (code_asm >= SURR_LO && code_asm <= SURR_HI)) begin
            err_nxt = ERR_RANGE;
          end
        end
      end
    end

    res.char_count = char_total_nxt;
    if (err_nxt != ERR_NONE) begin
      res.error_kind = err_nxt;
    end else if (pending_nxt != 2'd0) begin
      res.error_kind = ERR_TRUNC;
    end else if (char_total_nxt > max_code_points) begin
      res.error_kind = ERR_TOO_MANY;
    end else begin
      res.error_kind = ERR_NONE;
    end
    res.text_ok = (res.error_kind == ERR_NONE);
  end

  always_comb begin
    ob_wr_nxt  = ob_wr_r;
    ob_rd_nxt  = ob_rd_r;
    ob_cnt_nxt = ob_cnt_r;
    if (ob_push) begin
      ob_wr_nxt = (ob_wr_r == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ob_wr_r + 1'b1;
    end
    if (ob_pop) begin
      ob_rd_nxt = (ob_rd_r == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ob_rd_r + 1'b1;
    end
    if (ob_push && !ob_pop) begin
      ob_cnt_nxt = ob_cnt_r + 1'b1;
    end else if (ob_pop && !ob_push) begin
      ob_cnt_nxt = ob_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      obuf[ob_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_total_r <= '0;
      pending_r    <= '0;
      partial_r    <= '0;
      min_cls_r    <= '0;
      err_r        <= ERR_NONE;
      ob_wr_r      <= '0;
      ob_rd_r      <= '0;
      ob_cnt_r     <= '0;
    end else begin
      ob_wr_r  <= ob_wr_nxt;
      ob_rd_r  <= ob_rd_nxt;
      ob_cnt_r <= ob_cnt_nxt;
      if (step) begin
        if (q_rdata.last) begin
          char_total_r <= '0;
          pending_r    <= '0;
          partial_r    <= '0;
          min_cls_r    <= '0;
          err_r        <= ERR_NONE;
        end else begin
          char_total_r <= char_total_nxt;
          pending_r    <= pending_nxt;
          partial_r    <= partial_nxt;
          min_cls_r    <= min_cls_nxt;
          err_r        <= err_nxt;
        end
      end
    end
  end

endmodule

// ===== rtl/utf8_text_validator.sv =====
// Top level of the UTF-8 text validator: configuration registers and the
// front end, queue and back end. Depends on utv_pkg, utv_front, utv_queue, utv_back.
//
// Usage:
//   Bytes of a message enter through push/full with in_data_byte; the last
//   byte of a message carries in_final_byte. Every word is accepted at an
//   edge where push is high and full is low. One result word per message
//   leaves through empty/pop: out_text_ok, out_error_kind and out_char_count.
//   Limits max_bytes (address 0) and max_code_points (address 4) are written
//   over the APB port; the user must write them only while the block is idle,
//   which the block itself does not enforce. pready is always high.
//   Throughput is one byte per cycle while full is low. A message's final
//   byte is written into the byte queue when accepted; the decoder decodes it
//   into the result buffer once that has room, and empty then goes low.
//   When the receiver stops popping, the two-entry result buffer fills, the
//   decoder stops draining the four-entry byte queue, and full rises once
//   that queue is full; no word is dropped.
//   Reset clears both queues and the decode state and restores the limits to
//   8000 bytes and 2000 code points. No clearing pass follows reset.

module utf8_text_validator
  import utv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_text_ok,
  output logic [2:0]  out_error_kind,
  output logic [15:0] out_char_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_bytes_r;
  logic [15:0] max_cp_r;
  logic        cfg_wr;
  qstat_t      q_stat;
  logic        q_wr, q_rd;
  qentry_t     q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAX_CP) ? {16'd0, max_cp_r} : {16'd0, max_bytes_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RST;
      max_cp_r    <= MAX_CP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_BYTES) begin
        max_bytes_r <= pwdata[15:0];
      end else begin
        max_cp_r <= pwdata[15:0];
      end
    end
  end

  utv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .max_bytes     (max_bytes_r),
    .q_stat        (q_stat),
    .q_wr          (q_wr),
    .q_wdata       (q_wdata)
  );

  utv_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  utv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_rd            (q_rd),
    .max_code_points (max_cp_r),
    .empty           (empty),
    .pop             (pop),
    .out_text_ok     (out_text_ok),
    .out_error_kind  (out_error_kind),
    .out_char_count  (out_char_count)
  );

endmodule

// ===== tb/sv/utf8_text_validator_test.sv =====
// Self-checking testbench for utf8_text_validator: directed messages, then random
// text with idle bursts, receiver stalls and limit changes. Depends on utv_pkg and the RTL.
`timescale 1ns / 1ps

module utf8_text_validator_test;
  import utv_pkg::*;

  localparam int          CYCLE_LIMIT    = 200000;
  localparam logic [2:0]  ADDR_MAX_BYTES = {REG_MAX_BYTES, 2'b00};
  localparam logic [2:0]  ADDR_MAX_CP    = {REG_MAX_CP, 2'b00};

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_final_byte;
  logic        empty;
  logic        pop;
  logic        out_text_ok;
  logic [2:0]  out_error_kind;
  logic [15:0] out_char_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  utf8_text_validator dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_data_byte(in_data_byte), .in_final_byte(in_final_byte),
    .empty(empty), .pop(pop), .out_text_ok(out_text_ok), .out_error_kind(out_error_kind),
    .out_char_count(out_char_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Predictor state for the message in progress, plus its copy of the limits.
  logic [15:0] byte_limit;
  logic [15:0] char_limit;
  logic [15:0] msg_bytes;
  logic [15:0] msg_chars;
  logic [1:0]  cont_left;
  logic [20:0] code_acc;
  logic [1:0]  code_floor;
  err_kind_t   first_fault;

  result_t     expected_verdicts[$];
  logic [7:0]  message_bytes[$];
  int          mismatch_count;
  int          cycle_count;
  bit          sender_lazy;
  bit          calm_tail;
  bit          hold_requested;

  typedef struct packed {
    logic        set_lim;
    logic [15:0] lim_bytes;
    logic [15:0] lim_chars;
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic        ok;
    err_kind_t   kind;
    logic [15:0] count;
  } plan_row_t;

  localparam int PLAN_LEN = 29;
  plan_row_t plan [PLAN_LEN] = '{
    // Tab, newline and DEL are ordinary characters.
    '{1'b0, 16'd0, 16'd0, 8'h09, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h0A, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h7F, 1'b1, 1'b1, 1'b1, ERR_NONE, 16'd3},
    '{1'b0, 16'd0, 16'd0, 8'h00, 1'b1, 1'b1, 1'b0, ERR_BAD_LEAD, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'hFF, 1'b1, 1'b1, 1'b0, ERR_BAD_LEAD, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'hC1, 1'b1, 1'b1, 1'b0, ERR_BAD_LEAD, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'hDF, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'hBF, 1'b1, 1'b0, 1'b0, ERR_NONE, 16'd0},
    // Overlong three-byte form of a NUL.
    '{1'b0, 16'd0, 16'd0, 8'hE0, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h80, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h80, 1'b1, 1'b1, 1'b0, ERR_RANGE, 16'd1},
    // First surrogate.
    '{1'b0, 16'd0, 16'd0, 8'hED, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'hA0, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h80, 1'b1, 1'b1, 1'b0, ERR_RANGE, 16'd1},
    // Highest legal code point, then the first one above it.
    '{1'b0, 16'd0, 16'd0, 8'hF4, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h8F, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'hBF, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'hBF, 1'b1, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'hF4, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h90, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h80, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h80, 1'b1, 1'b1, 1'b0, ERR_RANGE, 16'd1},
    '{1'b0, 16'd0, 16'd0, 8'hE2, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h82, 1'b1, 1'b1, 1'b0, ERR_TRUNC, 16'd1},
    '{1'b0, 16'd0, 16'd0, 8'hC3, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h41, 1'b1, 1'b1, 1'b0, ERR_BAD_CONT, 16'd1},
    '{1'b1, 16'd1, 16'd1, 8'h41, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0},
    '{1'b0, 16'd0, 16'd0, 8'h42, 1'b1, 1'b1, 1'b0, ERR_TOO_LONG, 16'd1},
    '{1'b1, 16'hFFFF, 16'd1, 8'h41, 1'b0, 1'b0, 1'b0, ERR_NONE, 16'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_message();
    msg_bytes   = '0;
    msg_chars   = '0;
    cont_left   = '0;
    code_acc    = '0;
    code_floor  = '0;
    first_fault = ERR_NONE;
  endfunction

  function automatic void open_char(input logic [1:0] due, input logic [20:0] bits,
                                    input logic [1:0] floor_class);
    cont_left  = due;
    code_acc   = bits;
    code_floor = floor_class;
    if (msg_chars != 16'hFFFF) msg_chars++;
  endfunction

  // Advances the predictor by one byte; returns 1 with the verdict on a final byte.
  function automatic bit verdict_for_byte(input logic [7:0] b, input logic last,
                                          output result_t verdict);
    logic [20:0] lowest;
    err_kind_t   kind;
    verdict = '0;
    if (msg_bytes >= byte_limit) first_fault = ERR_TOO_LONG;
    if (msg_bytes != 16'hFFFF) msg_bytes++;
    if (first_fault == ERR_NONE) begin
      if (cont_left == 2'd0) begin
        if (b < 8'h80) begin
          if (b < 8'h20 && b != 8'h0A && b != 8'h09) first_fault = ERR_BAD_LEAD;
          else open_char(2'd0, 21'd0, 2'd0);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          open_char(2'd1, {16'd0, b[4:0]}, 2'd1);
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          open_char(2'd2, {17'd0, b[3:0]}, 2'd2);
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          open_char(2'd3, {18'd0, b[2:0]}, 2'd3);
        end else begin
          first_fault = ERR_BAD_LEAD;
        end
      end else if (b[7:6] != 2'b10) begin
        first_fault = ERR_BAD_CONT;
      end else begin
        code_acc  = {code_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          lowest = (code_floor == 2'd1) ? CP_MIN_2B :
                   (code_floor == 2'd2) ? CP_MIN_3B : CP_MIN_4B;
          if (code_acc < lowest || code_acc > CP_MAX ||
              (code_acc >= SURR_LO && code_acc <= SURR_HI))
            first_fault = ERR_RANGE;
        end
      end
    end
    if (!last) return 1'b0;
    if (first_fault != ERR_NONE)   kind = first_fault;
    else if (cont_left != 2'd0)    kind = ERR_TRUNC;
    else if (msg_chars > char_limit) kind = ERR_TOO_MANY;
    else                           kind = ERR_NONE;
    verdict.text_ok    = (kind == ERR_NONE);
    verdict.error_kind = kind;
    verdict.char_count = msg_chars;
    clear_message();
    return 1'b1;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    message_bytes.insert(message_bytes.size(), b);
  endfunction

  // Encodes cp in exactly len bytes, so overlong and out-of-range forms come out too.
  function automatic void append_utf8(input logic [20:0] cp, input int len);
    case (len)
      1: add_byte(cp[7:0]);
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Mostly well-formed text with the odd defect; some pure noise and cut-off endings.
  function automatic void build_message();
    int          n;
    int          mode;
    int          pick;
    int          len;
    logic [20:0] cp;
    message_bytes.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) add_byte(8'($urandom));
      return;
    end
    n = $urandom_range(1, 10);
    repeat (n) begin
      pick = ($urandom_range(0, 14) == 0) ? 4 + $urandom_range(0, 6) : $urandom_range(0, 3);
      case (pick)
        0: begin
          if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 2))
              0: add_byte(8'h09);
              1: add_byte(8'h0A);
              default: add_byte(8'h7F);
            endcase
          end else begin
            add_byte(8'($urandom_range(8'h20, 8'h7E)));
          end
        end
        1: append_utf8(21'($urandom_range(21'h80, 21'h7FF)), 2);
        2: begin
          cp = 21'($urandom_range(21'h800, 21'hFFFF));
          if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h800;
          append_utf8(cp, 3);
        end
        3: append_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
        4: add_byte(8'($urandom));
        5: begin
          len = $urandom_range(2, 4);
          cp  = (len == 2) ? 21'($urandom_range(0, 21'h7F)) :
                (len == 3) ? 21'($urandom_range(0, 21'h7FF)) : 21'($urandom_range(0, 21'hFFFF));
          append_utf8(cp, len);
        end
        6: append_utf8(21'($urandom_range(SURR_LO, SURR_HI)), 3);
        7: append_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        8: add_byte(8'($urandom_range(0, 31)));
        9: add_byte({2'b10, 6'($urandom)});
        default: begin
          // A lead byte followed by something that is not a continuation.
          append_utf8(21'($urandom_range(21'h80, 21'h7FF)), 2);
          message_bytes[$] = 8'($urandom_range(0, 127));
        end
      endcase
    end
    if (mode == 1) begin
      append_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
      repeat ($urandom_range(1, 3)) void'(message_bytes.pop_back());
    end
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic last, input bit typed,
                          input result_t typed_verdict);
    result_t guess;
    if (sender_lazy && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push          <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= last;
    do @(posedge clk); while (full);
    if (verdict_for_byte(b, last, guess))
      expected_verdicts.insert(expected_verdicts.size(), typed ? typed_verdict : guess);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all results and let the byte pipeline settle before touching the limits.
  task automatic set_limits(input logic [15:0] nb, input logic [15:0] nc);
    push <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write(ADDR_MAX_BYTES, nb);
    cfg_write(ADDR_MAX_CP, nc);
    byte_limit = nb;
    char_limit = nc;
  endtask

  initial begin : stimulus
    result_t     typed_verdict;
    int          sent;
    int          target;
    logic [15:0] nb;
    logic [15:0] nc;
    rst_n          <= 1'b0;
    push           <= 1'b0;
    in_data_byte   <= 8'd0;
    in_final_byte  <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    mismatch_count = 0;
    calm_tail      = 1'b0;
    hold_requested = 1'b0;
    sender_lazy    = 1'b1;
    byte_limit     = MAX_BYTES_RST;
    char_limit     = MAX_CP_RST;
    clear_message();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].set_lim) set_limits(plan[r].lim_bytes, plan[r].lim_chars);
      typed_verdict.text_ok    = plan[r].ok;
      typed_verdict.error_kind = plan[r].kind;
      typed_verdict.char_count = plan[r].count;
      put_byte(plan[r].data, plan[r].last, plan[r].typed, typed_verdict);
    end
    // The last row leaves a message open; with one code point allowed, a second is too many.
    typed_verdict.text_ok    = 1'b0;
    typed_verdict.error_kind = ERR_TOO_MANY;
    typed_verdict.char_count = 16'd2;
    put_byte(8'h42, 1'b1, 1'b1, typed_verdict);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin nb = 16'hFFFF; nc = 16'hFFFF; end
        1: begin nb = 16'd1; nc = 16'd1; end
        3: begin nb = MAX_BYTES_RST; nc = MAX_CP_RST; end
        default: begin
          nb = 16'($urandom_range(2, 48));
          nc = 16'($urandom_range(1, 12));
        end
      endcase
      set_limits(nb, nc);
      if (phase == 0) hold_requested = 1'b1;
      if (phase == 4) calm_tail = 1'b1;
      target = (phase == 1) ? 100 : 240;
      sent = 0;
      while (sent < target) begin
        build_message();
        sender_lazy = !calm_tail && ($urandom_range(0, 2) != 0);
        foreach (message_bytes[i])
          put_byte(message_bytes[i], i == message_bytes.size() - 1, 1'b0, '0);
        sent += message_bytes.size();
      end
    end

    push <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin : result_drain
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_requested) begin
        // Long hold so the result buffer and byte queue both fill and full rises.
        hold_requested = 1'b0;
        stall_left = 400;
      end else if (stall_left == 0 && !calm_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && pop && !empty) begin
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word: text_ok=%0b error_kind=%0d char_count=%0d",
                 $time, out_text_ok, out_error_kind, out_char_count);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_text_ok !== want.text_ok) begin
          mismatch_count++;
          $display("%0t: text_ok expected %0b got %0b", $time, want.text_ok, out_text_ok);
        end
        if (out_error_kind !== want.error_kind) begin
          mismatch_count++;
          $display("%0t: error_kind expected %0d got %0d", $time, want.error_kind,
                   out_error_kind);
        end
        if (out_char_count !== want.char_count) begin
          mismatch_count++;
          $display("%0t: char_count expected %0d got %0d", $time, want.char_count,
                   out_char_count);
        end
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
